>>> rtl/rpst_pkg.sv
// ----------------------------------------------------------------------------
// rpst_pkg - radio PHY state tracker package
// Field widths, default time/span widths and the event, state and status
// codes shared by the channel interfaces, the tracker and its bench.
// ----------------------------------------------------------------------------
`default_nettype none

package rpst_pkg;

  // Default widths of timestamps and durations (ns)
  localparam int TIME_WIDTH_DEF = 48;
  localparam int SPAN_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int MODE_W   = 4;
  localparam int PHY_W    = 3;
  localparam int STATUS_W = 2;

  // Event codes
  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY  = 4'd0,
    MODE_TX     = 4'd1,
    MODE_RX     = 4'd2,
    MODE_SWITCH = 4'd3,
    MODE_CCA    = 4'd4,
    MODE_RX_END = 4'd5,
    MODE_SLEEP  = 4'd6,
    MODE_WAKE   = 4'd7,
    MODE_OFF    = 4'd8,
    MODE_ON     = 4'd9
  } mode_t;

  // PHY states
  typedef enum logic [PHY_W-1:0] {
    ST_IDLE  = 3'd0,
    ST_CCA   = 3'd1,
    ST_TX    = 3'd2,
    ST_RX    = 3'd3,
    ST_SW    = 3'd4,
    ST_SLEEP = 3'd5,
    ST_OFF   = 3'd6
  } phy_state_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ILLEGAL = 2'd1,
    STAT_ASLEEP  = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rpst_ifs.sv
// ----------------------------------------------------------------------------
// rpst_ifs - channel interfaces of the radio PHY state tracker
// Event item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// Event items: mode, timestamp and duration
interface rpst_in_if #(
  parameter int TIME_WIDTH = rpst_pkg::TIME_WIDTH_DEF,
  parameter int SPAN_WIDTH = rpst_pkg::SPAN_WIDTH_DEF
);
  import rpst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [TIME_WIDTH-1:0] now_time;
  logic [SPAN_WIDTH-1:0] span;

  modport source (output valid, mode, now_time, span, input ready);
  modport sink   (input valid, mode, now_time, span, output ready);
endinterface

// Result items: state after the event and the timing figures
interface rpst_out_if #(
  parameter int TIME_WIDTH = rpst_pkg::TIME_WIDTH_DEF,
  parameter int SPAN_WIDTH = rpst_pkg::SPAN_WIDTH_DEF
);
  import rpst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PHY_W-1:0]      phy_state;
  logic [SPAN_WIDTH-1:0] idle_delay;
  logic [TIME_WIDTH-1:0] time_in_state;
  logic [SPAN_WIDTH-1:0] cca_left;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, phy_state, idle_delay, time_in_state, cca_left, status,
                  input ready);
  modport sink   (input valid, phy_state, idle_delay, time_in_state, cca_left, status,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/radio_phy_state_tracker.sv
// ----------------------------------------------------------------------------
// radio_phy_state_tracker - radio PHY state tracker
// Follows the PHY state (off, sleep, tx, rx, switching, CCA busy, idle) from
// timestamped events, rejects illegal transitions and reports one result
// item per event item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  in_ch     sink       valid/ready   mode, now_time, span
//  out_ch    source     valid/ready   phy_state, idle_delay, time_in_state,
//                                     cca_left, status
//
//  One item per cycle while out_ch does not stall; each item passes the
//  input register, then the result register, before its result is offered.
//  The tracker state is updated in the same cycle as the result register,
//  so the next item always sees the state left by the previous one.
//  Synchronous active-low reset clears the tracker state and both valid flags.
//  A stalled result holds the input register; in_ch.ready falls only when
//  both registers are full and out_ch.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_phy_state_tracker #(
  parameter int TIME_WIDTH = rpst_pkg::TIME_WIDTH_DEF,
  parameter int SPAN_WIDTH = rpst_pkg::SPAN_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  rpst_in_if.sink     in_ch,
  rpst_out_if.source  out_ch
);
  import rpst_pkg::*;

  // Widths for saturating arithmetic
  localparam int MAX_W = (TIME_WIDTH > SPAN_WIDTH) ? TIME_WIDTH : SPAN_WIDTH;
  localparam int SUM_W = MAX_W + 1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam logic [SPAN_WIDTH-1:0] SPAN_MAX = '1;

  // now + span, saturating at the largest timestamp
  function automatic logic [TIME_WIDTH-1:0] add_sat(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [SPAN_WIDTH-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s[SUM_W-1:TIME_WIDTH] != '0) return TIME_MAX;
    return s[TIME_WIDTH-1:0];
  endfunction

  // end - now, clamped at zero and saturating at the largest span
  function automatic logic [SPAN_WIDTH-1:0] left_sat(input logic [TIME_WIDTH-1:0] e,
                                                     input logic [TIME_WIDTH-1:0] now);
    logic [MAX_W-1:0] d;
    d = '0;
    if (e <= now) return '0;
    d = MAX_W'(e - now);
    if (d > MAX_W'(SPAN_MAX)) return SPAN_MAX;
    return SPAN_WIDTH'(d);
  endfunction

  // State by priority
  function automatic phy_state_t cur_state(input logic off, input logic slp, input logic rx,
                                           input logic [TIME_WIDTH-1:0] txe,
                                           input logic [TIME_WIDTH-1:0] swe,
                                           input logic [TIME_WIDTH-1:0] ccae,
                                           input logic [TIME_WIDTH-1:0] now);
    if (off)         return ST_OFF;
    if (slp)         return ST_SLEEP;
    if (txe > now)   return ST_TX;
    if (rx)          return ST_RX;
    if (swe > now)   return ST_SW;
    if (ccae > now)  return ST_CCA;
    return ST_IDLE;
  endfunction

  // Input register
  logic                  in_v_r;
  logic [MODE_W-1:0]     mode_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [SPAN_WIDTH-1:0] span_r;

  // Tracker state
  logic                  off_r, off_nxt;
  logic                  sleep_r, sleep_nxt;
  logic                  rx_r, rx_nxt;
  logic [TIME_WIDTH-1:0] tx_end_r, tx_end_nxt;
  logic [TIME_WIDTH-1:0] rx_end_r, rx_end_nxt;
  logic [TIME_WIDTH-1:0] cca_end_r, cca_end_nxt;
  logic [TIME_WIDTH-1:0] sw_end_r, sw_end_nxt;
  logic [TIME_WIDTH-1:0] last_chg_r, last_chg_nxt;

  // Result register
  logic                  out_v_r;
  phy_state_t            phy_r, phy_nxt;
  logic [SPAN_WIDTH-1:0] delay_r, delay_nxt;
  logic [TIME_WIDTH-1:0] tis_r, tis_nxt;
  logic [SPAN_WIDTH-1:0] cca_left_r, cca_left_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic                  in_ready;
  logic                  adv;
  phy_state_t            st_pre;
  logic                  bad;
  logic                  report_cca;
  logic [TIME_WIDTH-1:0] end_sum;

  // Handshake: the item in the input register moves on when the result slot is free
  assign adv      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !in_v_r || adv;
  assign in_ch.ready = in_ready;

  // Event handling and result
  always_comb begin
    off_nxt      = off_r;
    sleep_nxt    = sleep_r;
    rx_nxt       = rx_r;
    tx_end_nxt   = tx_end_r;
    rx_end_nxt   = rx_end_r;
    cca_end_nxt  = cca_end_r;
    sw_end_nxt   = sw_end_r;
    last_chg_nxt = last_chg_r;
    bad          = 1'b0;
    report_cca   = 1'b0;
    end_sum      = add_sat(now_r, span_r);
    st_pre       = cur_state(off_r, sleep_r, rx_r, tx_end_r, sw_end_r, cca_end_r, now_r);

    case (mode_r)
      MODE_QUERY: begin
      end
      MODE_TX: begin
        if (st_pre inside {ST_IDLE, ST_CCA, ST_RX}) begin
          if (st_pre == ST_RX) begin
            rx_nxt     = 1'b0;
            rx_end_nxt = now_r;
          end
          tx_end_nxt   = end_sum;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_RX: begin
        if (st_pre inside {ST_IDLE, ST_CCA}) begin
          rx_nxt       = 1'b1;
          rx_end_nxt   = end_sum;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_SWITCH: begin
        if (st_pre inside {ST_IDLE, ST_CCA, ST_RX}) begin
          if (st_pre == ST_RX) begin
            rx_nxt     = 1'b0;
            rx_end_nxt = now_r;
          end
          if (now_r < cca_end_r) cca_end_nxt = now_r;
          sw_end_nxt   = end_sum;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_CCA: begin
        if (end_sum > cca_end_r) cca_end_nxt = end_sum;
      end
      MODE_RX_END: begin
        if (st_pre == ST_RX) begin
          rx_nxt       = 1'b0;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_SLEEP: begin
        if (st_pre inside {ST_IDLE, ST_CCA, ST_OFF}) begin
          sleep_nxt    = 1'b1;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_WAKE: begin
        if (st_pre == ST_SLEEP) begin
          sleep_nxt    = 1'b0;
          last_chg_nxt = now_r;
          if (end_sum > cca_end_r) cca_end_nxt = end_sum;
          report_cca   = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_OFF: begin
        if (st_pre inside {ST_IDLE, ST_CCA, ST_RX, ST_TX, ST_SLEEP}) begin
          if (st_pre == ST_RX) begin
            rx_nxt     = 1'b0;
            rx_end_nxt = now_r;
          end
          if (st_pre == ST_TX) tx_end_nxt = now_r;
          off_nxt      = 1'b1;
          last_chg_nxt = now_r;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_ON: begin
        if (st_pre == ST_OFF) begin
          off_nxt      = 1'b0;
          last_chg_nxt = now_r;
          if (end_sum > cca_end_r) cca_end_nxt = end_sum;
          report_cca   = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // State after the event and its figures
    phy_nxt = cur_state(off_nxt, sleep_nxt, rx_nxt, tx_end_nxt, sw_end_nxt, cca_end_nxt,
                        now_r);
    case (phy_nxt)
      ST_TX:   delay_nxt = left_sat(tx_end_nxt, now_r);
      ST_RX:   delay_nxt = left_sat(rx_end_nxt, now_r);
      ST_SW:   delay_nxt = left_sat(sw_end_nxt, now_r);
      ST_CCA:  delay_nxt = left_sat(cca_end_nxt, now_r);
      default: delay_nxt = '0;
    endcase

    tis_nxt      = (now_r > last_chg_nxt) ? (now_r - last_chg_nxt) : '0;
    cca_left_nxt = report_cca ? left_sat(cca_end_nxt, now_r) : '0;

    if (bad)                                         status_nxt = STAT_ILLEGAL;
    else if (phy_nxt == ST_SLEEP || phy_nxt == ST_OFF) status_nxt = STAT_ASLEEP;
    else                                             status_nxt = STAT_OK;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
    if (in_ch.valid && in_ready) begin
      mode_r <= in_ch.mode;
      now_r  <= in_ch.now_time;
      span_r <= in_ch.span;
    end
  end

  // Tracker state, updated as each item completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= 1'b0;
      sleep_r    <= 1'b0;
      rx_r       <= 1'b0;
      tx_end_r   <= '0;
      rx_end_r   <= '0;
      cca_end_r  <= '0;
      sw_end_r   <= '0;
      last_chg_r <= '0;
    end else if (adv) begin
      off_r      <= off_nxt;
      sleep_r    <= sleep_nxt;
      rx_r       <= rx_nxt;
      tx_end_r   <= tx_end_nxt;
      rx_end_r   <= rx_end_nxt;
      cca_end_r  <= cca_end_nxt;
      sw_end_r   <= sw_end_nxt;
      last_chg_r <= last_chg_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (adv) begin
      phy_r      <= phy_nxt;
      delay_r    <= delay_nxt;
      tis_r      <= tis_nxt;
      cca_left_r <= cca_left_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.phy_state     = phy_r;
  assign out_ch.idle_delay    = delay_r;
  assign out_ch.time_in_state = tis_r;
  assign out_ch.cca_left      = cca_left_r;
  assign out_ch.status        = status_r;

  // Checks
  a_ok_not_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (phy_r == ST_SLEEP || phy_r == ST_OFF) |-> status_r != STAT_OK)
    else $error("ok status reported while asleep or off");

  a_no_delay_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (phy_r == ST_IDLE || phy_r == ST_SLEEP || phy_r == ST_OFF)
      |-> delay_r == '0)
    else $error("idle delay non-zero in a non-busy state");

  a_cca_left_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && cca_left_r != '0 |-> status_r != STAT_ILLEGAL)
    else $error("cca left reported for an ignored event");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled without a stalled result");

endmodule

`default_nettype wire

>>> tb/tb_radio_phy_state_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_phy_state_tracker - self-checking bench for the PHY state tracker
// Drives timestamped event items through the valid/ready input channel and
// checks every result item against an in-bench predictor of the tracker.
// A directed opening covers each event, the illegal cases, saturation and
// time running backwards. Random traffic then follows the predicted state, so
// most events are legal, under several idling and back-pressure phases.
// ----------------------------------------------------------------------------

module tb_radio_phy_state_tracker;
  import rpst_pkg::*;

  localparam int TW             = TIME_WIDTH_DEF;
  localparam int SW             = SPAN_WIDTH_DEF;
  localparam int EV_CODE_MAX    = (1 << MODE_W) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 350;
  localparam int PRESSURE_ITEMS = 250;
  localparam int TAIL_ITEMS     = 200;

  typedef logic [TW-1:0] ns_t;
  typedef logic [SW-1:0] dur_t;

  localparam ns_t TMAX = '1;

  localparam logic [MODE_W-1:0] EV_UNKNOWN_TOP = MODE_W'(EV_CODE_MAX);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PHY_W-1:0]    phy;
    dur_t                idle_delay;
    ns_t                 time_in_state;
    dur_t                cca_left;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  // Tracker predictor and store of predicted results
  class phy_tracker_sb;
    bit       off_f, sleep_f, rx_f;
    ns_t      tx_end, rx_end, cca_end, sw_end, last_chg;
    outcome_t predicted[$];
    int       errors, events, checked, illegal, cca_reports;
    bit [6:0] states_seen;

    function new();
      off_f = 0; sleep_f = 0; rx_f = 0;
      tx_end = '0; rx_end = '0; cca_end = '0; sw_end = '0; last_chg = '0;
      errors = 0; events = 0; checked = 0; illegal = 0; cca_reports = 0;
      states_seen = '0;
    endfunction

    // State by priority at a given time
    function phy_state_t state_at(ns_t now);
      if (off_f) return ST_OFF;
      if (sleep_f) return ST_SLEEP;
      if (tx_end > now) return ST_TX;
      if (rx_f) return ST_RX;
      if (sw_end > now) return ST_SW;
      if (cca_end > now) return ST_CCA;
      return ST_IDLE;
    endfunction

    // now + span, saturating at the top of the time range
    function ns_t end_after(ns_t now, dur_t span);
      logic [TW:0] s;
      s = now;
      s = s + span;
      if (s[TW]) return TMAX;
      return s[TW-1:0];
    endfunction

    // Time left until an end point, clamped at zero and at the span range
    function dur_t left_until(ns_t fin, ns_t now);
      ns_t d;
      if (fin <= now) return '0;
      d = fin - now;
      if (|d[TW-1:SW]) return '1;
      return d[SW-1:0];
    endfunction

    function void abort_rx(phy_state_t st, ns_t now);
      if (st == ST_RX) begin
        rx_f   = 1'b0;
        rx_end = now;
      end
    endfunction

    // Apply an accepted event and queue the result it should give
    function void note_event(logic [MODE_W-1:0] mode, ns_t now, dur_t span);
      phy_state_t st;
      bit         bad;
      bit         show_cca;
      ns_t        e;
      outcome_t   exp;
      st = state_at(now);
      bad = 1'b0;
      show_cca = 1'b0;
      e = end_after(now, span);
      case (mode)
        MODE_QUERY: ;
        MODE_TX: begin
          if (st == ST_IDLE || st == ST_CCA || st == ST_RX) begin
            abort_rx(st, now);
            tx_end = e;
            last_chg = now;
          end else bad = 1'b1;
        end
        MODE_RX: begin
          if (st == ST_IDLE || st == ST_CCA) begin
            rx_f = 1'b1;
            rx_end = e;
            last_chg = now;
          end else bad = 1'b1;
        end
        MODE_SWITCH: begin
          if (st == ST_IDLE || st == ST_CCA || st == ST_RX) begin
            abort_rx(st, now);
            if (now < cca_end) cca_end = now;
            sw_end = e;
            last_chg = now;
          end else bad = 1'b1;
        end
        MODE_CCA: begin
          if (e > cca_end) cca_end = e;
        end
        MODE_RX_END: begin
          if (st == ST_RX) begin
            rx_f = 1'b0;
            last_chg = now;
          end else bad = 1'b1;
        end
        MODE_SLEEP: begin
          if (st == ST_IDLE || st == ST_CCA || st == ST_OFF) begin
            sleep_f = 1'b1;
            last_chg = now;
          end else bad = 1'b1;
        end
        MODE_WAKE, MODE_ON: begin
          if ((mode == MODE_WAKE && st == ST_SLEEP) || (mode == MODE_ON && st == ST_OFF)) begin
            if (mode == MODE_WAKE) sleep_f = 1'b0;
            else off_f = 1'b0;
            last_chg = now;
            if (e > cca_end) cca_end = e;
            show_cca = 1'b1;
          end else bad = 1'b1;
        end
        MODE_OFF: begin
          if (st == ST_IDLE || st == ST_CCA || st == ST_RX || st == ST_TX ||
              st == ST_SLEEP) begin
            abort_rx(st, now);
            if (st == ST_TX) tx_end = now;
            off_f = 1'b1;
            last_chg = now;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase

      // Result as seen after the event
      st = state_at(now);
      exp.phy = st;
      case (st)
        ST_TX:   exp.idle_delay = left_until(tx_end, now);
        ST_RX:   exp.idle_delay = left_until(rx_end, now);
        ST_SW:   exp.idle_delay = left_until(sw_end, now);
        ST_CCA:  exp.idle_delay = left_until(cca_end, now);
        default: exp.idle_delay = '0;
      endcase
      exp.time_in_state = (now > last_chg) ? now - last_chg : '0;
      exp.cca_left = show_cca ? left_until(cca_end, now) : '0;
      if (bad) exp.status = STAT_ILLEGAL;
      else if (st == ST_SLEEP || st == ST_OFF) exp.status = STAT_ASLEEP;
      else exp.status = STAT_OK;

      events++;
      if (bad) illegal++;
      if (show_cca) cca_reports++;
      states_seen[st] = 1'b1;
      predicted = {predicted, exp};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result item against the oldest prediction
    task check_result(outcome_t got);
      outcome_t exp;
      if (predicted.size() == 0) begin
        report_mismatch("result item arrived with no prediction waiting");
        return;
      end
      exp = predicted.pop_front();
      if (got.phy !== exp.phy)
        report_mismatch($sformatf("result %0d phy_state %0h, predicted %0h",
                                  checked, got.phy, exp.phy));
      if (got.idle_delay !== exp.idle_delay)
        report_mismatch($sformatf("result %0d idle_delay %0h, predicted %0h",
                                  checked, got.idle_delay, exp.idle_delay));
      if (got.time_in_state !== exp.time_in_state)
        report_mismatch($sformatf("result %0d time_in_state %0h, predicted %0h",
                                  checked, got.time_in_state, exp.time_in_state));
      if (got.cca_left !== exp.cca_left)
        report_mismatch($sformatf("result %0d cca_left %0h, predicted %0h",
                                  checked, got.cca_left, exp.cca_left));
      if (got.status !== exp.status)
        report_mismatch($sformatf("result %0d status %0h, predicted %0h",
                                  checked, got.status, exp.status));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  rpst_in_if  in_ch ();
  rpst_out_if out_ch ();

  radio_phy_state_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  phy_tracker_sb sb;
  bit  sender_idle;
  int  send_pct;
  bit  stall_on;
  int  stall_pct;
  bit  hold_req;
  ns_t clock_ns;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, one long hold-off on request, checking
  initial begin : result_sink
    int       hold_left;
    outcome_t got;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(stall_on && $urandom_range(0, 99) < stall_pct);
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.phy           = out_ch.phy_state;
        got.idle_delay    = out_ch.idle_delay;
        got.time_in_state = out_ch.time_in_state;
        got.cca_left      = out_ch.cca_left;
        got.status        = out_ch.status;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
                 quiet, sb.predicted.size());
        $display("tb_radio_phy_state_tracker: done, errors");
        $finish;
      end
    end
  end

  // Offer one event item and wait for it to be taken; starts and ends at a falling edge
  task automatic send_event(input logic [MODE_W-1:0] mode, input ns_t now, input dur_t span);
    if (sender_idle) begin
      while ($urandom_range(0, 99) < send_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.now_time <= now;
    in_ch.span     <= span;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_event(mode, now, span);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.predicted.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(idle_mode_t m);
    sender_idle = (m == IDLE_SENDER || m == IDLE_BOTH);
    stall_on    = (m == IDLE_RECEIVER || m == IDLE_BOTH);
    send_pct    = (m == IDLE_BOTH) ? 15 : 74;
    stall_pct   = (m == IDLE_BOTH) ? 15 : 74;
  endtask

  // Mostly an event that is legal in the predicted state, now and then anything
  function automatic logic [MODE_W-1:0] pick_mode(phy_state_t st);
    mode_t opts[$];
    if ($urandom_range(0, 99) < 15) return MODE_W'($urandom_range(0, EV_UNKNOWN_TOP));
    case (st)
      ST_IDLE, ST_CCA:
        opts = {MODE_QUERY, MODE_TX, MODE_RX, MODE_RX, MODE_SWITCH, MODE_CCA, MODE_SLEEP,
                MODE_OFF};
      ST_TX:   opts = {MODE_QUERY, MODE_CCA, MODE_OFF};
      ST_RX:   opts = {MODE_TX, MODE_SWITCH, MODE_CCA, MODE_RX_END, MODE_RX_END, MODE_OFF};
      ST_SW:   opts = {MODE_QUERY, MODE_CCA};
      ST_SLEEP: opts = {MODE_WAKE, MODE_WAKE, MODE_OFF, MODE_CCA};
      default: opts = {MODE_ON, MODE_ON, MODE_SLEEP, MODE_CCA};
    endcase
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  // Durations: mostly short so that busy states run out between events
  function automatic dur_t pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2000);
    if (r < 90) return $urandom_range(0, 100000);
    return $urandom;
  endfunction

  // Time mostly creeps forward; rare jumps anywhere and small steps back
  function automatic ns_t next_time(ns_t t);
    int  r;
    ns_t hi;
    ns_t step;
    r = $urandom_range(0, 999);
    if (r < 15) begin
      hi = ns_t'($urandom_range(0, 65535));
      return (hi << 32) | ns_t'($urandom);
    end
    if (r < 25 && t > 600) return t - ns_t'($urandom_range(1, 500));
    step = ns_t'($urandom_range(0, 1500));
    if (t > TMAX - step) return TMAX;
    return t + step;
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      clock_ns = next_time(clock_ns);
      send_event(pick_mode(sb.state_at(clock_ns)), clock_ns, pick_span());
    end
  endtask

  // Main sequence
  initial begin : stimulus
    sb = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.now_time = '0;
    in_ch.span     = '0;
    hold_req       = 1'b0;
    clock_ns       = '0;
    set_idling(IDLE_NONE);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: each event, illegal events, saturation, time going back
    send_event(MODE_QUERY, 48'd0, '0);
    send_event(MODE_RX_END, 48'd1, 32'd5);       // rx end while idle
    send_event(MODE_WAKE, 48'd2, 32'd5);         // wake while not asleep
    send_event(MODE_ON, 48'd3, 32'd5);           // on while not off
    send_event(EV_UNKNOWN_TOP, 48'd4, '1);       // unknown event code
    send_event(MODE_CCA, 48'd10, 32'd100);
    send_event(MODE_RX, 48'd20, 32'd500);
    send_event(MODE_RX, 48'd30, 32'd500);        // rx while receiving
    send_event(MODE_TX, 48'd40, 32'd300);        // tx aborts the rx
    send_event(MODE_OFF, 48'd50, '0);            // off cuts the tx
    send_event(MODE_SLEEP, 48'd60, '0);          // sleep while off, off wins
    send_event(MODE_ON, 48'd70, 32'd1000);       // on clears off, sleep remains, reports CCA
    send_event(MODE_WAKE, 48'd80, '1);           // wake with the longest span
    send_event(MODE_SWITCH, 48'd90, 32'd200);    // switch cuts the CCA
    send_event(MODE_TX, 48'd100, 32'd50);        // tx while switching
    send_event(MODE_RX, 48'd400, '0);
    send_event(MODE_RX_END, 48'd500, '0);
    send_event(MODE_QUERY, 48'd450, '0);         // time runs backwards
    send_event(MODE_TX, TMAX - 48'd10, '1);      // end time saturates
    send_event(MODE_CCA, TMAX, '1);
    send_event(MODE_OFF, TMAX, '0);
    send_event(MODE_ON, TMAX, 32'd5);
    send_event(MODE_CCA, 48'h0100_0000_0000, 32'd1000);
    send_event(MODE_QUERY, 48'd5, '0);           // delay beyond the span range
    send_event(MODE_OFF, 48'd5, '0);
    drain();

    // Random traffic under each idling pattern
    clock_ns = 48'd6;
    send_random(PHASE_ITEMS);
    drain();
    set_idling(IDLE_SENDER);
    send_random(PHASE_ITEMS);
    drain();
    set_idling(IDLE_RECEIVER);
    send_random(PHASE_ITEMS);
    drain();
    set_idling(IDLE_BOTH);
    send_random(PHASE_ITEMS);
    drain();

    // Long receiver hold-off while items keep coming, so the input backs up
    set_idling(IDLE_NONE);
    hold_req = 1'b1;
    send_random(PRESSURE_ITEMS);
    drain();

    set_idling(IDLE_BOTH);
    send_random(TAIL_ITEMS);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.predicted.size() != 0)
      sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                   sb.predicted.size()));
    $display("covered %0d events: %0d flagged illegal, %0d with CCA reported on wake/on",
             sb.events, sb.illegal, sb.cca_reports);
    $display("checked %0d results, PHY states seen (bit per state) %b, %0d mismatches",
             sb.checked, sb.states_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_radio_phy_state_tracker: done, clean");
    end else begin
      $display("tb_radio_phy_state_tracker: done, errors");
    end
    $finish;
  end

endmodule
